// ===== src/wslc_pkg.sv =====
package wslc_pkg;

  localparam int unsigned MAX_WIDTH = 80;

  localparam logic [6:0] LINE_WIDTH_RESET = 7'd80;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_LINE_WIDTH = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP,
    S_RD,
    S_WR,
    S_ZERO
  } wslc_state_e;

endpackage

// ===== src/wslc_line_mem.sv =====
module wslc_line_mem #(
  parameter int unsigned MaxWidth = wslc_pkg::MAX_WIDTH,
  localparam int unsigned NRow = (MaxWidth + 7) / 8,
  localparam int unsigned RW = (NRow > 1) ? $clog2(NRow) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [RW-1:0] waddr_i,
  input  logic [2:0]    wbyte_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [RW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  // eight characters per row, byte writes
  logic [63:0] line_mem [NRow];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      line_mem[waddr_i][{wbyte_i, 3'b000} +: 8] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= line_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/word_squeeze_line_center_unit.sv =====
// Whitespace squeezer and line centering unit. Characters come in one item each
// (cmd 0), an end item (cmd 1) closes the text. Spaces and tabs at the start and
// end are dropped and inner runs collapse to one space. Squeezed text is cut into
// lines of line_width characters (clamped to 1..MaxWidth) held in a line memory
// of eight-byte rows; a full line goes out as soon as it fills, and the partial
// line left at the end goes out centered, in 64-bit words of up to eight
// characters. A separator item is taken by its accept alone. A character item
// takes the accept and one memory write, with a held space written ahead of it.
// A line flush forms each output word from a row read from the line memory
// followed by the load of the output register; an end item is its accept plus
// its flush, or a zero word with an empty line. A stalled output register
// holds up any flush or zero word. Input is stalled from the cycle after a
// character or end item is accepted until the append or the flush is done.
// Stored characters are only read back after they are written, so the memory
// needs no clearing after reset.
module word_squeeze_line_center_unit #(
  parameter int unsigned MaxWidth = wslc_pkg::MAX_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  ch_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] chars_o,
  output logic [3:0]  count_o,
  output logic        line_end_o,
  output logic        text_end_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NRow = (MaxWidth + 7) / 8;
  localparam int unsigned RW   = (NRow > 1) ? $clog2(NRow) : 1;
  localparam int unsigned PW   = $clog2(NRow * 8 + 1);
  localparam int unsigned JW   = PW - 3;
  localparam int unsigned CMPW = (PW > 7) ? PW : 7;

  // ---------------------------------------------------------------- config
  logic [6:0] line_width_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == wslc_pkg::REG_LINE_WIDTH);
  assign prdata = (paddr[2] == wslc_pkg::REG_LINE_WIDTH) ? {25'd0, line_width_q} : 32'd0;

  logic [CMPW-1:0] lw_ext;
  logic [PW-1:0]   eff_w;

  assign lw_ext = CMPW'(line_width_q);

  always_comb begin
    priority if (line_width_q == 7'd0) begin
      eff_w = PW'(1);
    end else if (lw_ext > CMPW'(MaxWidth)) begin
      eff_w = PW'(MaxWidth);
    end else begin
      eff_w = lw_ext[PW-1:0];
    end
  end

  // ---------------------------------------------------------------- state
  wslc_pkg::wslc_state_e state_q, state_d;

  logic [PW-1:0] fill_q;
  logic          sp_pend_q;
  logic          word_seen_q;

  logic [7:0]    ch_q;
  logic          do_space_q;
  logic          ret_app_q;
  logic [JW-1:0] j_q;
  logic [PW-1:0] n_q;
  logic [PW-1:0] total_q;
  logic [PW-1:0] pre_q;
  logic          tend_q;
  logic [63:0]   prev_q;

  logic          out_valid_q;
  logic [63:0]   chars_q;
  logic [3:0]    count_q;
  logic          line_end_q;
  logic          text_end_q;

  logic          accept;
  logic          is_sep;
  logic          out_free;
  logic          load_word;
  logic          load_zero;

  assign accept   = in_valid_i && !in_stall_o;
  assign is_sep   = (ch_i == wslc_pkg::CHAR_SPACE) || (ch_i == wslc_pkg::CHAR_TAB);
  assign out_free = !out_valid_q || !out_stall_i;

  // append path
  logic [7:0]    app_char;
  logic          app_store;
  logic [PW-1:0] new_fill;
  logic          app_full;

  assign app_char  = do_space_q ? wslc_pkg::CHAR_SPACE : ch_q;
  assign app_store = fill_q < PW'(MaxWidth);
  assign new_fill  = app_store ? fill_q + PW'(1) : fill_q;
  assign app_full  = new_fill >= eff_w;

  // centering of the final line
  logic [PW-1:0] end_total;
  logic [PW-1:0] end_pad;

  assign end_total = (eff_w > fill_q) ? eff_w : fill_q;
  assign end_pad   = end_total - fill_q;

  // ---------------------------------------------------------------- memory
  logic [JW-1:0] pre_row;
  logic [JW-1:0] rd_row;
  logic [63:0]   rdata;
  logic          mem_we;
  logic          mem_re;

  assign pre_row = pre_q[PW-1:3];
  assign rd_row  = (j_q >= pre_row) ? j_q - pre_row : '0;
  assign mem_we  = (state_q == wslc_pkg::S_APP) && app_store;
  assign mem_re  = (state_q == wslc_pkg::S_RD);

  wslc_line_mem #(
    .MaxWidth(MaxWidth)
  ) u_line_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(fill_q[RW+2:3]),
    .wbyte_i(fill_q[2:0]),
    .wdata_i(app_char),
    .re_i   (mem_re),
    .raddr_i(rd_row[RW-1:0]),
    .rdata_o(rdata)
  );

  // ---------------------------------------------------------------- word forming
  logic [PW-1:0]  base_pos;
  logic [PW-1:0]  end_pos;
  logic [PW-1:0]  rem;
  logic           word_last;
  logic [3:0]     word_cnt;
  logic [127:0]   cat_w;
  logic [63:0]    word_d;
  logic [PW-1:0]  byte_pos;
  logic [3:0]     sel_idx;

  assign base_pos  = {j_q, 3'b000};
  assign end_pos   = pre_q + n_q;
  assign rem       = total_q - base_pos;
  assign word_last = rem <= PW'(8);
  assign word_cnt  = word_last ? rem[3:0] : 4'd8;
  assign cat_w     = {rdata, prev_q};

  // bytes below pre_q[2:0] come from the previous row, the rest from the current one
  always_comb begin
    word_d   = '0;
    byte_pos = '0;
    sel_idx  = '0;
    for (int b = 0; b < 8; b++) begin
      byte_pos = base_pos + PW'(b);
      sel_idx  = 4'(b) + 4'd8 - {1'b0, pre_q[2:0]};
      priority if (byte_pos >= total_q) begin
        word_d[8*b +: 8] = 8'd0;
      end else if ((byte_pos < pre_q) || (byte_pos >= end_pos)) begin
        word_d[8*b +: 8] = wslc_pkg::CHAR_SPACE;
      end else begin
        word_d[8*b +: 8] = cat_w[{sel_idx, 3'b000} +: 8];
      end
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    load_word  = 1'b0;
    load_zero  = 1'b0;
    unique case (state_q)
      wslc_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (cmd_i == wslc_pkg::CMD_END) begin
            state_d = (fill_q == '0) ? wslc_pkg::S_ZERO : wslc_pkg::S_RD;
          end else if (!is_sep) begin
            state_d = wslc_pkg::S_APP;
          end
        end
      end
      wslc_pkg::S_APP: begin
        if (app_full) begin
          state_d = wslc_pkg::S_RD;
        end else if (!do_space_q) begin
          state_d = wslc_pkg::S_IDLE;
        end
      end
      wslc_pkg::S_RD: begin
        state_d = wslc_pkg::S_WR;
      end
      wslc_pkg::S_WR: begin
        if (out_free) begin
          load_word = 1'b1;
          if (!word_last) begin
            state_d = wslc_pkg::S_RD;
          end else if (ret_app_q) begin
            state_d = wslc_pkg::S_APP;
          end else begin
            state_d = wslc_pkg::S_IDLE;
          end
        end
      end
      wslc_pkg::S_ZERO: begin
        if (out_free) begin
          load_zero = 1'b1;
          state_d   = wslc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wslc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wslc_pkg::S_IDLE;
      fill_q       <= '0;
      sp_pend_q    <= 1'b0;
      word_seen_q  <= 1'b0;
      line_width_q <= wslc_pkg::LINE_WIDTH_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        line_width_q <= pwdata[6:0];
      end
      if (load_word || load_zero) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        if (cmd_i == wslc_pkg::CMD_END) begin
          fill_q      <= '0;
          sp_pend_q   <= 1'b0;
          word_seen_q <= 1'b0;
        end else if (is_sep) begin
          if (word_seen_q) begin
            sp_pend_q <= 1'b1;
          end
        end else begin
          sp_pend_q   <= 1'b0;
          word_seen_q <= 1'b1;
        end
      end
      if (state_q == wslc_pkg::S_APP) begin
        fill_q <= app_full ? '0 : new_fill;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q       <= ch_i;
      do_space_q <= sp_pend_q;
      if (cmd_i == wslc_pkg::CMD_END) begin
        n_q       <= fill_q;
        total_q   <= end_total;
        pre_q     <= end_pad >> 1;
        tend_q    <= 1'b1;
        ret_app_q <= 1'b0;
        j_q       <= '0;
      end
    end
    if (state_q == wslc_pkg::S_APP) begin
      do_space_q <= 1'b0;
      if (app_full) begin
        n_q       <= new_fill;
        total_q   <= new_fill;
        pre_q     <= '0;
        tend_q    <= 1'b0;
        ret_app_q <= do_space_q;
        j_q       <= '0;
      end
    end
    if (load_word) begin
      prev_q     <= rdata;
      j_q        <= j_q + JW'(1);
      chars_q    <= word_d;
      count_q    <= word_cnt;
      line_end_q <= word_last;
      text_end_q <= word_last && tend_q;
    end else if (load_zero) begin
      chars_q    <= '0;
      count_q    <= '0;
      line_end_q <= 1'b0;
      text_end_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign chars_o     = chars_q;
  assign count_o     = count_q;
  assign line_end_o  = line_end_q;
  assign text_end_o  = text_end_q;

  // ---------------------------------------------------------------- checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= PW'(MaxWidth))
    else $error("line fill beyond memory size");

  a_word_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_word |=> (count_o != 4'd0))
    else $error("flushed word carries no characters");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == wslc_pkg::CMD_END)) |=> ((fill_q == '0) && !word_seen_q && !sp_pend_q))
    else $error("end item left line state behind");

  a_text_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_end_o) |-> (line_end_o || (count_o == 4'd0)))
    else $error("text end on a word that does not close a line");

endmodule
